// ===== design/bmhq_pkg.sv =====
`default_nettype none

package bmhq_pkg;

    // Heap capacity in keys.
    localparam int DEPTH  = 1024;

    localparam int KEY_W  = 64;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 11;

    // Key count and 1-based heap positions both fit in CNT_W bits.
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = CNT_W;
    // One cell per tree level.
    localparam int LEVELS = CNT_W;
    localparam int LVL_W  = $clog2(LEVELS);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic
    {
        OP_PUSH,
        OP_SIFT
    } op_t;

    // Work token passed down the chain of level cells.
    // Push: pos is the target position, shift is the number of levels left.
    // Sift: pos is the hole position at the receiving level, count the keys held.
    typedef struct packed
    {
        logic              valid;
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  pos;
        logic [LVL_W-1:0]  shift;
        logic [CNT_W-1:0]  count;
    } tok_t;

    // Child read request: parent position, children live in the next level.
    typedef struct packed
    {
        logic              valid;
        logic [POS_W-1:0]  pos;
    } creq_t;

    typedef struct packed
    {
        logic              valid;
        logic [POS_W-1:0]  pos;
    } fetch_t;

    typedef struct packed
    {
        logic              valid;
        logic [LVL_W-1:0]  level;
        logic [POS_W-1:0]  pos;
    } ctl_fetch_t;

    typedef struct packed
    {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [KEY_W-1:0]  wdata;
        logic [POS_W-1:0]  raddr_a;
        logic [POS_W-1:0]  raddr_b;
    } mem_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== design/bmhq_ram.sv =====
`default_nettype none

module bmhq_ram #(
    parameter int AW = 4,
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem_q [0:(1 << AW) - 1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem_q[raddr_a];
        rdata_b <= mem_q[raddr_b];
    end

endmodule

`default_nettype wire

// ===== design/bmhq_cell.sv =====
`default_nettype none

module bmhq_cell
    import bmhq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tok_t             tok_in,
    output tok_t                  tok_out,
    input  wire creq_t            creq_in,
    output creq_t                 creq_out,
    input  wire fetch_t           fetch_in,
    input  wire logic [KEY_W-1:0] rd_a,
    input  wire logic [KEY_W-1:0] child_a,
    input  wire logic [KEY_W-1:0] child_b,
    output mem_req_t              mem_req,
    output cell_stat_t            stat
);

    typedef enum logic [1:0]
    {
        C_IDLE,
        C_PUSH_CMP,
        C_SIFT_WAIT
    } cstate_t;

    cstate_t           state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LVL_W-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [POS_W:0]    in_lc;
    logic [POS_W:0]    lc_pos;
    logic [POS_W:0]    rc_pos;
    logic              rc_valid;
    logic [KEY_W-1:0]  best_key;
    logic [POS_W-1:0]  best_pos;
    logic [POS_W-1:0]  in_here;
    logic [POS_W-1:0]  reg_here;

    always_comb
    begin
        in_lc    = {tok_in.pos, 1'b0};
        lc_pos   = {pos_reg, 1'b0};
        rc_pos   = {pos_reg, 1'b1};
        rc_valid = (rc_pos <= {1'b0, count_reg});
        in_here  = tok_in.pos >> tok_in.shift;
        reg_here = pos_reg >> shift_reg;

        // prefer the left child on a tie
        if (rc_valid && ($signed(child_b) < $signed(child_a)))
        begin
            best_key = child_b;
            best_pos = rc_pos[POS_W-1:0];
        end
        else
        begin
            best_key = child_a;
            best_pos = lc_pos[POS_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        count_next = count_reg;

        mem_req.we      = 1'b0;
        mem_req.waddr   = pos_reg;
        mem_req.wdata   = key_reg;
        mem_req.raddr_a = in_here;
        mem_req.raddr_b = in_here;

        // parent asks for both children, else controller fetch, else own push read
        if (creq_in.valid)
        begin
            mem_req.raddr_a = {creq_in.pos[POS_W-2:0], 1'b0};
            mem_req.raddr_b = {creq_in.pos[POS_W-2:0], 1'b1};
        end
        else if (fetch_in.valid)
        begin
            mem_req.raddr_a = fetch_in.pos;
        end

        tok_out   = '0;
        creq_out  = '0;
        stat.busy = (state_reg != C_IDLE);
        stat.done = 1'b0;

        unique case (state_reg)
            C_IDLE:
            begin
                if (tok_in.valid)
                begin
                    key_next   = tok_in.key;
                    pos_next   = tok_in.pos;
                    shift_next = tok_in.shift;
                    count_next = tok_in.count;
                    if (tok_in.op == OP_PUSH)
                    begin
                        if (tok_in.shift == '0)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = in_here;
                            mem_req.wdata = tok_in.key;
                            stat.done     = 1'b1;
                        end
                        else
                        begin
                            state_next = C_PUSH_CMP;
                        end
                    end
                    else
                    begin
                        if (in_lc <= {1'b0, tok_in.count})
                        begin
                            creq_out.valid = 1'b1;
                            creq_out.pos   = tok_in.pos;
                            state_next     = C_SIFT_WAIT;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = tok_in.pos;
                            mem_req.wdata = tok_in.key;
                            stat.done     = 1'b1;
                        end
                    end
                end
            end

            C_PUSH_CMP:
            begin
                // keep the smaller key here, carry the larger one down
                mem_req.we    = 1'b1;
                mem_req.waddr = reg_here;
                tok_out.valid = 1'b1;
                tok_out.op    = OP_PUSH;
                tok_out.pos   = pos_reg;
                tok_out.shift = shift_reg - LVL_W'(1);
                if ($signed(key_reg) < $signed(rd_a))
                begin
                    mem_req.wdata = key_reg;
                    tok_out.key   = rd_a;
                end
                else
                begin
                    mem_req.wdata = rd_a;
                    tok_out.key   = key_reg;
                end
                state_next = C_IDLE;
            end

            C_SIFT_WAIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if ($signed(best_key) < $signed(key_reg))
                begin
                    // pull the child up, move the hole down
                    mem_req.wdata = best_key;
                    tok_out.valid = 1'b1;
                    tok_out.op    = OP_SIFT;
                    tok_out.key   = key_reg;
                    tok_out.pos   = best_pos;
                    tok_out.count = count_reg;
                end
                else
                begin
                    mem_req.wdata = key_reg;
                    stat.done     = 1'b1;
                end
                state_next = C_IDLE;
            end

            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            key_reg   <= '0;
            pos_reg   <= '0;
            shift_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bmhq_ctrl.sv =====
`default_nettype none

module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cmd,
    input  wire logic [KEY_W-1:0] key_in,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [KEY_W-1:0] key_out,
    output logic      [ST_W-1:0]  status,
    output logic      [OCC_W-1:0] occupancy,
    output tok_t                  tok_out,
    output ctl_fetch_t            fetch,
    input  wire logic [KEY_W-1:0] rd_root,
    input  wire logic [KEY_W-1:0] rd_last,
    input  wire logic             work_done
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FETCH,
        S_CAPT,
        S_ISSUE,
        S_WORK,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    tok_t              tok_reg, tok_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  key_out_reg, key_out_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  count_inc;

    function automatic logic [LVL_W-1:0] flog2(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (v[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = (state_reg == S_ISSUE);
        fetch.valid   = (state_reg == S_FETCH);
        fetch.level   = lvl_reg;
        fetch.pos     = last_pos_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lvl_next       = lvl_reg;
        last_pos_next  = last_pos_reg;
        tok_next       = tok_reg;
        res_key_next   = res_key_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        key_out_next   = key_out_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_key_next = '0;
                    res_st_next  = ST_OK;
                    if (cmd == CMD_PUSH)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            count_next     = count_inc;
                            tok_next.valid = 1'b1;
                            tok_next.op    = OP_PUSH;
                            tok_next.key   = key_in;
                            tok_next.pos   = count_inc;
                            tok_next.shift = flog2(count_inc);
                            tok_next.count = '0;
                            state_next     = S_ISSUE;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            count_next    = count_reg - CNT_W'(1);
                            lvl_next      = flog2(count_reg);
                            last_pos_next = count_reg;
                            state_next    = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                state_next = S_CAPT;
            end

            S_CAPT:
            begin
                // root is the answer, the last key restarts the sift at the root
                res_key_next   = rd_root;
                tok_next.valid = 1'b1;
                tok_next.op    = OP_SIFT;
                tok_next.key   = rd_last;
                tok_next.pos   = POS_W'(1);
                tok_next.shift = '0;
                tok_next.count = count_reg;
                state_next     = (count_reg == '0) ? S_FINISH : S_ISSUE;
            end

            S_ISSUE:
            begin
                state_next = work_done ? S_FINISH : S_WORK;
            end

            S_WORK:
            begin
                if (work_done)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    key_out_next   = res_key_reg;
                    status_next    = res_st_reg;
                    occ_next       = OCC_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lvl_reg       <= '0;
            last_pos_reg  <= '0;
            tok_reg       <= '0;
            res_key_reg   <= '0;
            res_st_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
            key_out_reg   <= '0;
            status_reg    <= ST_OK;
            occ_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lvl_reg       <= lvl_next;
            last_pos_reg  <= last_pos_next;
            tok_reg       <= tok_next;
            res_key_reg   <= res_key_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            key_out_reg   <= key_out_next;
            status_reg    <= status_next;
            occ_reg       <= occ_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        work_done |-> ((state_reg == S_ISSUE) || (state_reg == S_WORK)))
        else $error("cell finished while controller was not waiting on it");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("key count beyond capacity");

endmodule

`default_nettype wire

// ===== design/binary_min_heap_queue.sv =====
// A push walks the new key down from the root to its target level; a pop fetches the root and
// the last key, then sifts the moved key down until it stops above its children or lands on a
// childless node. A pop that empties the heap, an empty pop and a full push skip the walk.
// Throughput: one word at a time; in_ready comes back the cycle after the result is loaded.
// A result waiting in the output register holds the controller and stalls the input.
// Reset: rst_n low clears the count, control and result registers, not the heap memories.
`default_nettype none

module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    cmd,
    input  wire logic signed [KEY_W-1:0] key_in,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed      [KEY_W-1:0] key_out,
    output logic             [ST_W-1:0]  status,
    output logic             [OCC_W-1:0] occupancy
);

    // Token and child-read links between neighboring level cells.
    // tok[0] comes from the controller, creq[0] is tied off; the last entry must stay idle.
    tok_t        tok     [0:LEVELS];
    creq_t       creq    [0:LEVELS];
    fetch_t      fetch_c [0:LEVELS-1];
    mem_req_t    mem_req [0:LEVELS-1];
    cell_stat_t  stat    [0:LEVELS-1];
    logic [KEY_W-1:0] rda     [0:LEVELS-1];
    logic [KEY_W-1:0] rdb     [0:LEVELS-1];
    logic [KEY_W-1:0] child_a [0:LEVELS-1];
    logic [KEY_W-1:0] child_b [0:LEVELS-1];
    logic [LEVELS-1:0] busy_vec;
    logic [LEVELS-1:0] done_vec;
    logic [KEY_W-1:0]  key_out_raw;
    ctl_fetch_t        ctl_fetch;

    assign creq[0]  = '0;
    assign key_out  = key_out_raw;

    // Controller: count, result register, and launching work into level 0.
    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key_in    (key_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_out   (key_out_raw),
        .status    (status),
        .occupancy (occupancy),
        .tok_out   (tok[0]),
        .fetch     (ctl_fetch),
        .rd_root   (rda[0]),
        .rd_last   (rda[ctl_fetch.level]),
        .work_done (|done_vec)
    );

    // One cell and one dual-read memory per tree level; level g holds 2**g keys.
    genvar g;
    for (g = 0; g < LEVELS; g++)
    begin : g_level
        localparam int AW = (g == 0) ? 1 : g;

        logic [AW-1:0] waddr;
        logic [AW-1:0] raddr_a;
        logic [AW-1:0] raddr_b;

        // Root fetch always hits level 0; the last-key fetch hits its own level.
        assign fetch_c[g].valid = ctl_fetch.valid &&
                                  ((g == 0) || (ctl_fetch.level == LVL_W'(g)));
        assign fetch_c[g].pos   = (g == 0) ? POS_W'(1) : ctl_fetch.pos;

        assign busy_vec[g] = stat[g].busy;
        assign done_vec[g] = stat[g].done;

        if (g == 0)
        begin : g_root_addr
            assign waddr   = '0;
            assign raddr_a = '0;
            assign raddr_b = '0;
        end
        else
        begin : g_addr
            // drop the leading one of the position to get the index within the level
            assign waddr   = mem_req[g].waddr[AW-1:0];
            assign raddr_a = mem_req[g].raddr_a[AW-1:0];
            assign raddr_b = mem_req[g].raddr_b[AW-1:0];
        end

        if (g == LEVELS - 1)
        begin : g_leaf
            assign child_a[g] = '0;
            assign child_b[g] = '0;
        end
        else
        begin : g_inner
            assign child_a[g] = rda[g+1];
            assign child_b[g] = rdb[g+1];
        end

        bmhq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1]),
            .creq_in  (creq[g]),
            .creq_out (creq[g+1]),
            .fetch_in (fetch_c[g]),
            .rd_a     (rda[g]),
            .child_a  (child_a[g]),
            .child_b  (child_b[g]),
            .mem_req  (mem_req[g]),
            .stat     (stat[g])
        );

        bmhq_ram #(
            .AW (AW),
            .DW (KEY_W)
        ) u_ram (
            .clk     (clk),
            .we      (mem_req[g].we),
            .waddr   (waddr),
            .wdata   (mem_req[g].wdata),
            .raddr_a (raddr_a),
            .raddr_b (raddr_b),
            .rdata_a (rda[g]),
            .rdata_b (rdb[g])
        );
    end

    // Only one level cell holds work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(busy_vec))
        else $error("more than one level cell busy");

    // Taking a word means the previous walk has fully drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (busy_vec == '0))
        else $error("input ready while a level cell is busy");

    // Nothing may fall off the bottom of the tree.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(tok[LEVELS].valid || creq[LEVELS].valid))
        else $error("work passed below the last level");

endmodule

`default_nettype wire

// ===== sim/binary_min_heap_queue_tb.sv =====
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;

    import bmhq_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Long receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD = 400;
    // Settle time after the last expected word.
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_WORDS_PER_PHASE = 70;
    // Keys pushed to grow the heap past 512 entries, so walks reach level 9.
    localparam int DEEP_FILL = 520;

    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct
    {
        logic signed [KEY_W-1:0] key;
        logic [ST_W-1:0]         status;
        logic [OCC_W-1:0]        occ;
    } heap_word_t;

    // Shadow copy of the heap: predicts each result word and checks the block's answers.
    class min_heap_shadow;
        logic signed [KEY_W-1:0] slots [DEPTH];
        int                      held;
        heap_word_t              due_words [$];
        int                      mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // Apply one accepted input word to the shadow heap and queue its result.
        function void take_word(logic c, logic signed [KEY_W-1:0] k);
            heap_word_t              w;
            logic signed [KEY_W-1:0] tmp;
            int                      pos;
            int                      parent;
            int                      lc;
            int                      rc;
            int                      best;
            bit                      settled;

            w.key = '0;
            w.status = ST_OK;
            if (c == CMD_PUSH)
            begin
                if (held >= DEPTH)
                    w.status = ST_FULL;
                else
                begin
                    slots[held] = k;
                    pos = held;
                    held++;
                    settled = 1'b0;
                    while (pos > 0 && !settled)
                    begin
                        parent = (pos - 1) / 2;
                        if (slots[pos] < slots[parent])
                        begin
                            tmp = slots[pos];
                            slots[pos] = slots[parent];
                            slots[parent] = tmp;
                            pos = parent;
                        end
                        else
                            settled = 1'b1;
                    end
                end
            end
            else
            begin
                if (held == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    w.key = slots[0];
                    held--;
                    slots[0] = slots[held];
                    pos = 0;
                    settled = 1'b0;
                    while (!settled)
                    begin
                        lc = 2 * pos + 1;
                        rc = lc + 1;
                        best = pos;
                        // Left child wins a tie with the right one.
                        if (lc < held && slots[lc] < slots[best])
                            best = lc;
                        if (rc < held && slots[rc] < slots[best])
                            best = rc;
                        if (best == pos)
                            settled = 1'b1;
                        else
                        begin
                            tmp = slots[pos];
                            slots[pos] = slots[best];
                            slots[best] = tmp;
                            pos = best;
                        end
                    end
                end
            end
            w.occ = OCC_W'(held);
            due_words.push_back(w);
        endfunction

        function void check_word(logic signed [KEY_W-1:0] k, logic [ST_W-1:0] s,
                                 logic [OCC_W-1:0] o);
            heap_word_t w;

            if (due_words.size() == 0)
            begin
                $error("unexpected result word: key_out %0d status %0d occupancy %0d",
                       k, s, o);
                mismatches++;
            end
            else
            begin
                w = due_words.pop_front();
                if (k !== w.key)
                begin
                    $error("key_out mismatch: expected %0d, actual %0d", w.key, k);
                    mismatches++;
                end
                if (s !== w.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", w.status, s);
                    mismatches++;
                end
                if (o !== w.occ)
                begin
                    $error("occupancy mismatch: expected %0d, actual %0d", w.occ, o);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    cmd = CMD_PUSH;
    logic signed [KEY_W-1:0] key_in = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [KEY_W-1:0] key_out;
    logic [ST_W-1:0]         status;
    logic [OCC_W-1:0]        occupancy;

    // Idle and stall odds in percent, set by the main sequence per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Cycles left in a forced receiver hold-off; the receiver counts it down itself.
    int hold_left = 0;
    int quiet_cycles = 0;

    min_heap_shadow shadow;

    binary_min_heap_queue i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key_in    (key_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_out   (key_out),
        .status    (status),
        .occupancy (occupancy)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: check each accepted result word against the oldest prediction, then
    // pick the next ready level. A pending hold-off overrides the random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                shadow.check_word(key_out, status, occupancy);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL binary_min_heap_queue");
                $finish;
            end
        end
    end

    // Mix of key shapes: full random, a narrow band that forces repeats, the two
    // extremes, single set bits or their complements and sign-extended values of every magnitude.
    function automatic logic signed [KEY_W-1:0] random_key();
        logic signed [KEY_W-1:0] k;

        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                k = {$urandom(), $urandom()};
            4, 5, 6:
            begin
                k = KEY_W'($urandom_range(0, 40));
                k = k - 20;
            end
            7:
                k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
            8:
            begin
                k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                if ($urandom_range(0, 1))
                    k = ~k;
            end
            default:
                k = $signed({$urandom(), $urandom()}) >>> $urandom_range(0, KEY_W - 1);
        endcase
        return k;
    endfunction

    // Offer one word, idling first at random, and hold it until the block takes it.
    // Entered and left at a rising edge; it returns once in_ready is seen high after an edge.
    task automatic send_word(logic c, logic signed [KEY_W-1:0] k);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        key_in <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.take_word(c, k);
    endtask

    // Drop valid and hold off until every predicted result word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.pending() != 0);
    endtask

    // Bursts of random length, each leaning toward pushes or pops so the
    // occupancy wanders up and down instead of hovering in one place.
    task automatic run_random(int n_words);
        int  sent;
        int  push_pct;
        logic c;

        sent = 0;
        while (sent < n_words)
        begin
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 55;
                default: push_pct = 35;
            endcase
            repeat ($urandom_range(8, 40))
            begin
                c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                send_word(c, random_key());
                sent++;
            end
        end
    endtask

    initial
    begin
        shadow = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop on an empty heap, the key extremes, repeated keys, then
        // drain in order, pop past empty again, and push and pop a repeated key once more.
        send_word(CMD_POP, random_key());
        send_word(CMD_PUSH, '0);
        send_word(CMD_PUSH, KEY_MAX);
        send_word(CMD_PUSH, KEY_MIN);
        send_word(CMD_PUSH, -64'sd1);
        send_word(CMD_PUSH, 64'sd1);
        send_word(CMD_PUSH, KEY_MAX);
        send_word(CMD_PUSH, KEY_MIN);
        send_word(CMD_PUSH, 64'sd5);
        send_word(CMD_PUSH, 64'sd5);
        repeat (9)
            send_word(CMD_POP, random_key());
        send_word(CMD_POP, KEY_MAX);
        send_word(CMD_PUSH, 64'sd7);
        send_word(CMD_PUSH, 64'sd7);
        send_word(CMD_POP, KEY_MIN);
        send_word(CMD_POP, '0);
        wait_drained();

        // Grow a deep heap so pushes and pops walk down to level 9; the random
        // phases below then work on it.
        repeat (DEEP_FILL)
            send_word(CMD_PUSH, random_key());
        wait_drained();

        // Random phase with no idling on either side.
        run_random(RANDOM_WORDS_PER_PHASE);

        // Back the block up: hold the receiver off while words keep coming.
        hold_left = LONG_HOLD;
        repeat (8)
            send_word(CMD_PUSH, random_key());
        repeat (4)
            send_word(CMD_POP, random_key());
        wait_drained();

        // Sender idle most of the time.
        send_idle_pct = 77;
        run_random(RANDOM_WORDS_PER_PHASE);
        wait_drained();

        // Receiver stalling most of the time.
        send_idle_pct = 0;
        recv_stall_pct = 77;
        run_random(RANDOM_WORDS_PER_PHASE);
        wait_drained();

        // Both sides idle now and then.
        send_idle_pct = 35;
        recv_stall_pct = 35;
        run_random(RANDOM_WORDS_PER_PHASE);

        // Take everything back, then give stray words time to show up.
        recv_stall_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("PASS binary_min_heap_queue");
        else
            $display("FAIL binary_min_heap_queue");
        $finish;
    end

endmodule
